FILE: design/brrs_pkg.sv
// Shared constants and types for the blocking round-robin scheduler.
`default_nettype none
package brrs_pkg;

  localparam int unsigned NUM_TASKS = 5;
  localparam int unsigned TICK_BITS = 32;
  localparam int unsigned IDX_W     = (NUM_TASKS > 2) ? $clog2(NUM_TASKS) : 1;

  localparam int unsigned REQ_TICK  = 0;
  localparam int unsigned REQ_DELAY = 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic                 load;
    logic                 shift;
    logic                 tick_en;
    logic [TICK_BITS-1:0] tick_new;
    logic                 dly_en;
    logic [TICK_BITS-1:0] wake_new;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/brrs_cell.sv
// One task slot: blocked flag, wake tick and the round-robin search token.
`default_nettype none
module brrs_cell
  import brrs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       idle_i,
  input  wire logic       sel_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       tok_i,
  output logic            tok_o,
  output logic            blocked_o,
  output logic            hit_o
);

  logic                 tok_q, tok_d;
  logic                 blocked_q, blocked_d;
  logic [TICK_BITS-1:0] wake_q, wake_d;

  always_comb begin
    tok_d     = tok_q;
    blocked_d = blocked_q;
    wake_d    = wake_q;
    if (ctrl_i.load) begin
      tok_d = sel_i;
    end else if (ctrl_i.shift) begin
      tok_d = tok_i;
    end
    if (ctrl_i.tick_en && blocked_q && (wake_q == ctrl_i.tick_new)) begin
      blocked_d = 1'b0;
    end
    if (ctrl_i.dly_en && sel_i && !idle_i) begin
      blocked_d = 1'b1;
      wake_d    = ctrl_i.wake_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= 1'b0;
      blocked_q <= 1'b0;
    end else begin
      tok_q     <= tok_d;
      blocked_q <= blocked_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wake_q <= wake_d;
  end

  assign tok_o     = tok_q;
  assign blocked_o = blocked_q;
  assign hit_o     = ctrl_i.shift & tok_i & ~blocked_q & ~idle_i;

endmodule
`default_nettype wire

FILE: design/blocking_round_robin_scheduler_core.sv
// Top level: event sequencer, ring of task cells and result register.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid_i, in_stall_o, req_type_i,      | in
//          | delay_ticks_i                            |
//  output  | out_valid_o, out_stall_i, running_task_o,| out
//          | tick_now_o, blocked_mask_o               |
//
// An event is handled in steps: the counter and cells are updated, then the search
// token walks the ring cell by cell until it meets a ready task (the idle task is
// chosen if none is ready), then the result is loaded. A delay from the idle task skips the search.
// One event is in work at a time; the next transfer may be taken while a result
// waits on out_stall_i. Reset leaves task 1 running, counter zero and every
// task ready.
`default_nettype none
module blocking_round_robin_scheduler_core
  import brrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] delay_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       running_task_o,
  output logic [31:0]      tick_now_o,
  output logic [4:0]       blocked_mask_o
);

  state_e               state_q, state_d;
  logic [TICK_BITS-1:0] tick_q, tick_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [IDX_W-1:0]     step_q, step_d;
  logic [IDX_W-1:0]     pos_nxt;
  logic                 out_valid_q;
  logic [2:0]           running_task_q;
  logic [31:0]          tick_now_q;
  logic [4:0]           blocked_mask_q;

  logic                 accept;
  logic                 is_tick;
  logic                 cur_user;
  logic                 emit_load;
  logic                 any_hit;
  logic [TICK_BITS-1:0] tick_inc;
  logic [TICK_BITS+31:0] dly_ext;
  logic [IDX_W+2:0]     cur_ext;
  logic [TICK_BITS+31:0] tick_ext;
  logic [NUM_TASKS+4:0] mask_ext;
  cell_ctrl_t           ctrl;

  logic [NUM_TASKS-1:0] sel;
  logic [NUM_TASKS-1:0] tok;
  logic [NUM_TASKS-1:0] tok_in;
  logic [NUM_TASKS-1:0] blocked;
  logic [NUM_TASKS-1:0] hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_tick    = (req_type_i == 1'(REQ_TICK));
  assign cur_user   = (cur_q != '0);
  assign tick_inc   = tick_q + {{(TICK_BITS-1){1'b0}}, 1'b1};
  assign dly_ext    = {{TICK_BITS{1'b0}}, delay_ticks_i};
  assign any_hit    = |hit;
  assign pos_nxt    = (pos_q == IDX_W'(NUM_TASKS-1)) ? '0 : IDX_W'(pos_q + 1'b1);
  assign emit_load  = (state_q == ST_EMIT) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    ctrl.load     = accept & (is_tick | cur_user);
    ctrl.shift    = (state_q == ST_SCAN);
    ctrl.tick_en  = accept & is_tick;
    ctrl.tick_new = tick_inc;
    ctrl.dly_en   = accept & ~is_tick & cur_user;
    ctrl.wake_new = tick_q + dly_ext[TICK_BITS-1:0];
  end

  generate
    for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
      assign sel[i]    = (cur_q == IDX_W'(i));
      assign tok_in[i] = tok[(i + NUM_TASKS - 1) % NUM_TASKS];
      brrs_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .idle_i    (i == 0),
        .sel_i     (sel[i]),
        .ctrl_i    (ctrl),
        .tok_i     (tok_in[i]),
        .tok_o     (tok[i]),
        .blocked_o (blocked[i]),
        .hit_o     (hit[i])
      );
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    cur_d   = cur_q;
    pos_d   = pos_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d  = cur_q;
          step_d = '0;
          if (is_tick) begin
            tick_d  = tick_inc;
            state_d = ST_SCAN;
          end else if (cur_user) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        pos_d  = pos_nxt;
        step_d = IDX_W'(step_q + 1'b1);
        if (any_hit) begin
          cur_d   = pos_nxt;
          state_d = ST_EMIT;
        end else if (step_q == IDX_W'(NUM_TASKS-1)) begin
          cur_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      cur_q       <= IDX_W'(1);
      pos_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      cur_q   <= cur_d;
      pos_q   <= pos_d;
      step_q  <= step_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cur_ext  = {3'b000, cur_q};
  assign tick_ext = {32'h0, tick_q};
  assign mask_ext = {5'b00000, blocked};

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      running_task_q <= cur_ext[2:0];
      tick_now_q     <= tick_ext[31:0];
      blocked_mask_q <= mask_ext[4:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_task_o = running_task_q;
  assign tick_now_o     = tick_now_q;
  assign blocked_mask_o = blocked_mask_q;

endmodule
`default_nettype wire

FILE: tb/blocking_round_robin_scheduler_core_test.sv
// Self-checking testbench for the blocking round-robin scheduler core.
module blocking_round_robin_scheduler_core_test;
  import brrs_pkg::*;

  localparam bit EV_TICK      = 1'(REQ_TICK);
  localparam bit EV_DELAY     = 1'(REQ_DELAY);
  localparam int RCV_HOLD     = 80;
  localparam int TAIL_CYCLES  = 20;
  localparam int PHASE_EVENTS = 150;

  typedef struct {
    logic [2:0]  task_idx;
    logic [31:0] tick;
    logic [4:0]  blocked;
  } sched_result_t;

  class sched_tracker;
    bit [TICK_BITS-1:0] tick_cnt;
    bit [2:0]           cur_task;
    bit [NUM_TASKS-1:0] blocked;
    bit [TICK_BITS-1:0] wake [NUM_TASKS];
    sched_result_t      expected_picks [$];
    int unsigned        n_ticks, n_delays, n_idle_delays, n_wakeups, n_checked, n_errors;

    function new();
      tick_cnt = '0;
      cur_task = 3'd1;
      blocked  = '0;
      foreach (wake[i]) wake[i] = '0;
    endfunction

    function int unsigned pending();
      return expected_picks.size();
    endfunction

    function int unsigned effective();
      return n_ticks + n_delays;
    endfunction

    function void pick_next_task();
      int unsigned idx;
      idx = cur_task % NUM_TASKS;
      for (int n = 0; n < NUM_TASKS; n++) begin
        idx = (idx + 1) % NUM_TASKS;
        if (idx != 0 && !blocked[idx]) begin
          cur_task = 3'(idx);
          return;
        end
      end
      cur_task = '0;
    endfunction

    function void note_event(bit req, bit [31:0] ticks);
      int unsigned   cur;
      sched_result_t res;
      cur = cur_task % NUM_TASKS;
      if (req == REQ_TICK) begin
        n_ticks++;
        tick_cnt++;
        for (int i = 1; i < NUM_TASKS; i++) begin
          if (blocked[i] && wake[i] == tick_cnt) begin
            blocked[i] = 1'b0;
            n_wakeups++;
          end
        end
        pick_next_task();
      end else if (cur == 0) begin
        n_idle_delays++;
      end else begin
        n_delays++;
        wake[cur]    = tick_cnt + TICK_BITS'(ticks);
        blocked[cur] = 1'b1;
        pick_next_task();
      end
      res.task_idx = cur_task;
      res.tick     = 32'(tick_cnt);
      res.blocked  = 5'(blocked);
      expected_picks.push_back(res);
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      if (n_errors <= 50) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(logic [2:0] task_idx, logic [31:0] tick, logic [4:0] mask);
      sched_result_t want;
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result: task %0d tick %0d mask %b",
                                  task_idx, tick, mask));
        return;
      end
      want = expected_picks.pop_front();
      n_checked++;
      if (task_idx !== want.task_idx)
        report_mismatch($sformatf("running_task %0d, expected %0d", task_idx, want.task_idx));
      if (tick !== want.tick)
        report_mismatch($sformatf("tick_now %0d, expected %0d", tick, want.tick));
      if (mask !== want.blocked)
        report_mismatch($sformatf("blocked_mask %b, expected %b", mask, want.blocked));
    endtask
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        req_type_i     = 1'b0;
  logic [31:0] delay_ticks_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  running_task_o;
  logic [31:0] tick_now_o;
  logic [4:0]  blocked_mask_o;

  sched_tracker tracker;
  int unsigned  snd_idle_pct = 22;
  int unsigned  rcv_idle_pct = 50;
  logic         hold_req     = 1'b0;

  blocking_round_robin_scheduler_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_stall_i = 1'b1;
        repeat (RCV_HOLD) @(negedge clk_i);
      end
      out_stall_i = ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(running_task_o, tick_now_o, blocked_mask_o);
  end

  task automatic send_event(bit req, logic [31:0] ticks);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i    = 1'b0;
      delay_ticks_i = $urandom;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    req_type_i    = req;
    delay_ticks_i = ticks;
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_event(req, ticks);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  task automatic random_event();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55)
      send_event(EV_TICK, $urandom);
    else if (tracker.cur_task == 0)
      send_event(EV_DELAY, $urandom);
    else if (r < 93)
      send_event(EV_DELAY, $urandom_range(1, 12));
    else
      send_event(EV_DELAY, $urandom_range(13, 60));
  endtask

  task automatic run_directed();
    send_event(EV_TICK, '0);
    send_event(EV_DELAY, 32'd1);
    send_event(EV_TICK, 32'hFFFF_FFFF);
    // block every user task, two of them on the same wake tick
    send_event(EV_DELAY, 32'd4);
    send_event(EV_DELAY, 32'd3);
    send_event(EV_DELAY, 32'd4);
    send_event(EV_DELAY, 32'd2);
    // idle task running: drop these
    send_event(EV_DELAY, '0);
    send_event(EV_DELAY, 32'hFFFF_FFFF);
    send_event(EV_DELAY, 32'hAAAA_AAAA);
    send_event(EV_DELAY, 32'h5555_5555);
    repeat (5) send_event(EV_TICK, $urandom);
    send_event(EV_DELAY, 32'd1);
    send_event(EV_TICK, '0);
    send_event(EV_DELAY, 32'd12);
    send_event(EV_TICK, '0);
  endtask

  // zero and wide delays park a task for half a counter wrap or more, so leave them to the end
  task automatic run_wide_delays();
    logic [31:0] d;
    for (int k = 0; k < 3; k++) begin
      while (tracker.cur_task == 0) send_event(EV_TICK, $urandom);
      case (k)
        0:       d = '0;
        1:       d = 32'hFFFF_FFFF;
        default: d = $urandom | 32'h8000_0000;
      endcase
      send_event(EV_DELAY, d);
      send_event(EV_TICK, $urandom);
    end
    repeat (4) send_event(EV_TICK, $urandom);
  endtask

  initial begin
    int unsigned target;
    tracker = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      snd_idle_pct = (p == 0) ? 22 : (p == 1) ? 50 : 0;
      rcv_idle_pct = (p == 0) ? 50 : (p == 1) ? 22 : 0;
      if (p == 0) begin
        snd_idle_pct = 0;
        hold_req     = 1'b1;
        repeat (12) random_event();
        snd_idle_pct = 22;
      end
      target = tracker.effective() + PHASE_EVENTS;
      while (tracker.effective() < target) random_event();
      wait_drained();
    end

    run_wide_delays();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch("results still outstanding at end of run");

    $display("covered %0d ticks, %0d delays from user tasks, %0d dropped delays from idle",
             tracker.n_ticks, tracker.n_delays, tracker.n_idle_delays);
    $display("%0d wake-ups, %0d results checked, final tick count %0d",
             tracker.n_wakeups, tracker.n_checked, tracker.tick_cnt);
    if (tracker.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
